FILE: rtl/core/mamt_pkg.sv
// Package for the multi-alarm match table: operation and status codes,
// payload structs, controller state type and controller/datapath links.
// No dependencies.
package mamt_pkg;

    localparam int DEF_ALARM_SLOTS = 5;
    localparam int MASK_W          = 5;
    localparam int COUNT_OUT_W     = 3;

    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [5:0] MAX_MINUTE = 6'd59;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_TIME = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BAD_SLOT = 3'd4
    } status_e;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] slot;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] fired_mask;
        logic [2:0] entry_count;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_COMMIT = 2'd2,
        S_RESP   = 2'd3
    } ctrl_state_e;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic commit;
    } mamt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic commit_needed;
    } mamt_stat_t;

endpackage

FILE: rtl/core/mamt_ctrl.sv
// Controller for the multi-alarm match table: sequences load, decode,
// commit and response. Depends on mamt_pkg.
module mamt_ctrl
    import mamt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mamt_stat_t stat,
    output mamt_cmd_t  cmd
);

    ctrl_state_e state_reg;
    ctrl_state_e state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = stat.commit_needed ? S_COMMIT : S_RESP;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/mamt_dpath.sv
// Datapath for the multi-alarm match table: alarm entries, fired flags,
// entry count, validity checks and the result register. Depends on mamt_pkg.
module mamt_dpath
    import mamt_pkg::*;
#(
    parameter int ALARM_SLOTS = DEF_ALARM_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        in_data,
    input  mamt_cmd_t  cmd,
    output mamt_stat_t stat,
    output out_t       out_data
);

    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    in_t                    item_reg;
    status_e                status_reg;
    status_e                status_next;
    logic [MASK_W-1:0]      mask_reg;
    logic [MASK_W-1:0]      mask_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [ALARM_SLOTS-1:0] fired_reg;
    logic [ALARM_SLOTS-1:0] fired_next;
    logic [ALARM_SLOTS-1:0] fire_vec;
    logic [4:0]             hour_reg   [ALARM_SLOTS];
    logic [5:0]             minute_reg [ALARM_SLOTS];

    logic             full;
    logic             time_ok;
    logic [CMP_W-1:0] slot_ext;
    logic [CMP_W-1:0] count_ext;
    op_e              op;

    assign op        = op_e'(item_reg.operation);
    assign full      = (count_reg == CNT_W'(ALARM_SLOTS));
    assign time_ok   = (item_reg.hour <= MAX_HOUR) && (item_reg.minute <= MAX_MINUTE);
    assign slot_ext  = CMP_W'(item_reg.slot);
    assign count_ext = CMP_W'(count_reg);

    // Classify the held transaction
    always_comb
    begin
        status_next        = ST_OK;
        stat.commit_needed = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (!time_ok)
                begin
                    status_next = ST_BAD_TIME;
                end
                else
                begin
                    stat.commit_needed = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if ((slot_ext == '0) || (slot_ext > count_ext))
                begin
                    status_next = ST_BAD_SLOT;
                end
                else
                begin
                    stat.commit_needed = 1'b1;
                end
            end
            OP_CHECK:
            begin
                stat.commit_needed = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Next fired flags and count; check matches entries in use to the time
    always_comb
    begin
        fired_next = fired_reg;
        fire_vec   = '0;
        count_next = count_reg;
        case (op)
            OP_ADD:
            begin
                for (int i = 0; i < ALARM_SLOTS; i++)
                begin
                    if (count_reg == CNT_W'(i))
                    begin
                        fired_next[i] = 1'b0;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < ALARM_SLOTS - 1; i++)
                begin
                    if ((CMP_W'(i + 1) >= slot_ext) && (CNT_W'(i + 1) < count_reg))
                    begin
                        fired_next[i] = fired_reg[i + 1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
            OP_CHECK:
            begin
                for (int i = 0; i < ALARM_SLOTS; i++)
                begin
                    if (CNT_W'(i) < count_reg)
                    begin
                        if ((hour_reg[i] == item_reg.hour) &&
                            (minute_reg[i] == item_reg.minute))
                        begin
                            fire_vec[i]   = !fired_reg[i];
                            fired_next[i] = 1'b1;
                        end
                        else
                        begin
                            fired_next[i] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign mask_next = MASK_W'(fire_vec);

    // Hold the transaction, the result and the entry times
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.decode)
        begin
            status_reg <= status_next;
            mask_reg   <= '0;
        end
        if (cmd.commit)
        begin
            if (op == OP_CHECK)
            begin
                mask_reg <= mask_next;
            end
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                if ((op == OP_ADD) && (count_reg == CNT_W'(i)))
                begin
                    hour_reg[i]   <= item_reg.hour;
                    minute_reg[i] <= item_reg.minute;
                end
            end
            for (int i = 0; i < ALARM_SLOTS - 1; i++)
            begin
                if ((op == OP_REMOVE) && (CMP_W'(i + 1) >= slot_ext) &&
                    (CNT_W'(i + 1) < count_reg))
                begin
                    hour_reg[i]   <= hour_reg[i + 1];
                    minute_reg[i] <= minute_reg[i + 1];
                end
            end
        end
    end

    // Advance the count and fired flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fired_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
            fired_reg <= fired_next;
        end
    end

    assign out_data.status      = status_reg;
    assign out_data.fired_mask  = mask_reg;
    assign out_data.entry_count = COUNT_OUT_W'(count_reg);

endmodule

FILE: rtl/core/multi_alarm_match_table.sv
// Multi-alarm match table, top level. Each transaction is loaded,
// decoded, committed (accepted add and remove, and every check; rejected
// and idle transactions skip the commit) and then offered as a response
// until out_ready. One transaction is in flight at a time, so a new one
// is accepted only after the last response is taken. Reset clears the
// count and fired flags; entry times hold whatever was last written.
module multi_alarm_match_table
    import mamt_pkg::*;
#(
    parameter int ALARM_SLOTS = DEF_ALARM_SLOTS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    mamt_cmd_t  cmd;
    mamt_stat_t stat;

    // Sequence each transaction
    mamt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the table and compute the result
    mamt_dpath #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

FILE: verif/tb_multi_alarm_match_table.sv
// Self-checking testbench for multi_alarm_match_table: directed and random transactions
// against a cycle-free model of the alarm table, with random idling on both channels.
// Depends on mamt_pkg and the multi_alarm_match_table RTL.
module tb_multi_alarm_match_table
    import mamt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ALARM_SLOTS   = DEF_ALARM_SLOTS;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // Shadow copy of the alarm table
    logic [4:0]  shadow_hour [ALARM_SLOTS];
    logic [5:0]  shadow_minute [ALARM_SLOTS];
    bit          shadow_fired [ALARM_SLOTS];
    int unsigned shadow_count;

    out_t        expected_results [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          idling_on;
    int unsigned stall_left;
    logic [4:0]  last_check_hour;
    logic [5:0]  last_check_minute;
    out_t        oldest;

    multi_alarm_match_table #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic in_t make_item(op_e op, int unsigned h, int unsigned m, int unsigned s);
        in_t t;
        t.operation = op;
        t.hour      = h[4:0];
        t.minute    = m[5:0];
        t.slot      = s[2:0];
        return t;
    endfunction

    // Apply one transaction to the shadow table and return its result
    function automatic out_t alarm_table_step(in_t t);
        out_t r;
        int   k;
        r = '0;
        r.status = ST_OK;
        case (op_e'(t.operation))
            OP_ADD:
            begin
                if (shadow_count >= ALARM_SLOTS)
                    r.status = ST_FULL;
                else if (t.hour > MAX_HOUR || t.minute > MAX_MINUTE)
                    r.status = ST_BAD_TIME;
                else
                begin
                    shadow_hour[shadow_count]   = t.hour;
                    shadow_minute[shadow_count] = t.minute;
                    shadow_fired[shadow_count]  = 1'b0;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (t.slot == 0 || t.slot > shadow_count)
                    r.status = ST_BAD_SLOT;
                else
                begin
                    for (k = int'(t.slot) - 1; k + 1 < shadow_count; k++)
                    begin
                        shadow_hour[k]   = shadow_hour[k + 1];
                        shadow_minute[k] = shadow_minute[k + 1];
                        shadow_fired[k]  = shadow_fired[k + 1];
                    end
                    shadow_count--;
                end
            end
            OP_CHECK:
            begin
                for (k = 0; k < shadow_count; k++)
                begin
                    if (shadow_hour[k] == t.hour && shadow_minute[k] == t.minute)
                    begin
                        if (!shadow_fired[k])
                        begin
                            shadow_fired[k] = 1'b1;
                            if (k < MASK_W)
                                r.fired_mask[k] = 1'b1;
                        end
                    end
                    else
                        shadow_fired[k] = 1'b0;
                end
            end
            default: ;
        endcase
        r.entry_count = shadow_count[2:0];
        return r;
    endfunction

    // Offer one transaction after an optional gap; predict it once accepted
    task automatic send_item(in_t t);
        int unsigned gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            in_data  = in_t'(16'($urandom));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(alarm_table_step(t));
    endtask

    // Drop valid and hold until every result has been returned
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_item(make_item(OP_CHECK, 0, 0, 0));
        send_item(make_item(OP_REMOVE, 31, 63, 1));
        send_item(make_item(OP_NONE, 31, 63, 7));
        send_item(make_item(OP_CHECK, 31, 63, 7));
    endtask

    task automatic test_fill_table();
        send_item(make_item(OP_ADD, 0, 0, 0));
        send_item(make_item(OP_ADD, 24, 0, 0));
        send_item(make_item(OP_ADD, 0, 60, 0));
        send_item(make_item(OP_ADD, 31, 63, 7));
        send_item(make_item(OP_ADD, 23, 59, 0));
        send_item(make_item(OP_ADD, 23, 59, 0));
        send_item(make_item(OP_ADD, 12, 30, 0));
        send_item(make_item(OP_ADD, 0, 0, 0));
        // Full is reported ahead of a bad time
        send_item(make_item(OP_ADD, 12, 30, 0));
        send_item(make_item(OP_ADD, 31, 63, 0));
    endtask

    task automatic test_fire_once();
        send_item(make_item(OP_CHECK, 23, 59, 0));
        send_item(make_item(OP_CHECK, 23, 59, 0));
        send_item(make_item(OP_CHECK, 0, 0, 0));
        send_item(make_item(OP_CHECK, 23, 59, 0));
    endtask

    task automatic test_remove_shift();
        send_item(make_item(OP_REMOVE, 0, 0, 0));
        send_item(make_item(OP_REMOVE, 0, 0, 6));
        send_item(make_item(OP_REMOVE, 0, 0, 7));
        // Fired flag must move down with its entry
        send_item(make_item(OP_REMOVE, 0, 0, 2));
        send_item(make_item(OP_CHECK, 23, 59, 0));
        send_item(make_item(OP_REMOVE, 0, 0, 4));
        send_item(make_item(OP_REMOVE, 0, 0, 1));
        send_item(make_item(OP_REMOVE, 0, 0, 1));
        send_item(make_item(OP_REMOVE, 0, 0, 1));
    endtask

    // Random transactions biased towards hits on stored times
    function automatic in_t random_item();
        in_t         t;
        int unsigned r;
        int unsigned k;
        t = in_t'(16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            t.operation = OP_ADD;
            if ($urandom_range(0, 9) != 0)
            begin
                t.hour   = 5'($urandom_range(0, 23));
                t.minute = 6'($urandom_range(0, 59));
            end
        end
        else if (r < 55)
        begin
            t.operation = OP_REMOVE;
            if (shadow_count > 0 && $urandom_range(0, 6) != 0)
                t.slot = 3'($urandom_range(1, shadow_count));
        end
        else if (r < 95)
        begin
            t.operation = OP_CHECK;
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                t.hour   = last_check_hour;
                t.minute = last_check_minute;
            end
            else if (r < 8 && shadow_count > 0)
            begin
                k = $urandom_range(0, shadow_count - 1);
                t.hour   = shadow_hour[k];
                t.minute = shadow_minute[k];
            end
            else if (r < 9)
            begin
                t.hour   = 5'($urandom_range(0, 23));
                t.minute = 6'($urandom_range(0, 59));
            end
            last_check_hour   = t.hour;
            last_check_minute = t.minute;
        end
        else
            t.operation = OP_NONE;
        return t;
    endfunction

    task automatic test_random_traffic();
        int unsigned n;
        // Opening stretch runs back to back
        idling_on = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
                idling_on = 1'b1;
            if (n == 350)
                drain_results();
            send_item(random_item());
        end
    endtask

    // Receiver: random stalls while idling is on
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (idling_on && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each returned transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result status %0d mask %b count %0d", $time,
                         out_data.status, out_data.fired_mask, out_data.entry_count);
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (out_data.status !== oldest.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time,
                             oldest.status, out_data.status);
                end
                if (out_data.fired_mask !== oldest.fired_mask)
                begin
                    mismatches++;
                    $display("%0t: fired_mask expected %b got %b", $time,
                             oldest.fired_mask, out_data.fired_mask);
                end
                if (out_data.entry_count !== oldest.entry_count)
                begin
                    mismatches++;
                    $display("%0t: entry_count expected %0d got %0d", $time,
                             oldest.entry_count, out_data.entry_count);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_multi_alarm_match_table: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        mismatches        = 0;
        cycle_count       = 0;
        idling_on         = 1'b1;
        shadow_count      = 0;
        last_check_hour   = '0;
        last_check_minute = '0;
        for (int k = 0; k < ALARM_SLOTS; k++)
        begin
            shadow_hour[k]   = '0;
            shadow_minute[k] = '0;
            shadow_fired[k]  = 1'b0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_table();
        test_fire_once();
        test_remove_shift();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_multi_alarm_match_table: done, clean");
        else
            $display("tb_multi_alarm_match_table: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mamt_pkg.sv
rtl/core/mamt_ctrl.sv
rtl/core/mamt_dpath.sv
rtl/core/multi_alarm_match_table.sv
verif/tb_multi_alarm_match_table.sv
